[rtl/core/ccq_pkg.sv]
// shared types, codes and helpers of the coalescing command queue
package ccq_pkg;

    typedef struct packed {
        logic [4:0]  typ;
        logic [63:0] payload;
        logic [31:0] stamp;
    } ccq_entry_t;

    typedef struct packed {
        logic clear;
        logic shift_en;
        logic keep_head;
        logic append_en;
    } ccq_cell_ctrl_t;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_DRAIN = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [2:0] KIND_PUT_ACK   = 3'd0;
    localparam logic [2:0] KIND_DRAINED   = 3'd1;
    localparam logic [2:0] KIND_QUERY     = 3'd2;
    localparam logic [2:0] KIND_CLEAR_ACK = 3'd3;
    localparam logic [2:0] KIND_NONE      = 3'd4;

    localparam logic [1:0] POL_APPEND       = 2'd0;
    localparam logic [1:0] POL_REPLACE_ALL  = 2'd1;
    localparam logic [1:0] POL_REPLACE_LAST = 2'd2;
    localparam logic [1:0] POL_WINDOW       = 2'd3;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_WINDOW = 1'b1;

    localparam logic [15:0] WINDOW_RESET = 16'd500;

    function automatic logic [4:0] level5(input logic [31:0] v);
        return v[4:0];
    endfunction

endpackage

[rtl/core/ccq_cell.sv]
// one queue slot: takes its neighbor's entry on a shift, or the head when it is the tail
module ccq_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ccq_pkg::ccq_cell_ctrl_t ctrl,
    input  ccq_pkg::ccq_entry_t    head,
    input  ccq_pkg::ccq_entry_t    nbr,
    input  ccq_pkg::ccq_entry_t    new_entry,
    input  logic                   nbr_valid,
    input  logic                   prev_valid,
    output ccq_pkg::ccq_entry_t    entry,
    output logic                   valid
);
    import ccq_pkg::*;

    logic       valid_reg, valid_next;
    ccq_entry_t entry_reg, entry_next;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift_en)
        begin
            if (nbr_valid)
            begin
                entry_next = nbr;
                valid_next = 1'b1;
            end
            else if (valid_reg)
            begin
                // tail slot: the popped head comes back here if kept
                entry_next = head;
                valid_next = ctrl.keep_head;
            end
        end
        else if (ctrl.append_en && !valid_reg && prev_valid)
        begin
            entry_next = new_entry;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

[rtl/core/coalescing_command_queue.sv]
// coalescing command queue: a row of slot cells and the sequencer that walks them
//
// Commands come in on the valid/ready input channel, one beat per operation:
// put, drain unheld entries, query a type, or clear. Results leave on the
// valid/ready output channel; put, query and clear give one beat, a drain gives
// one beat per removed entry (or one "nothing found" beat), last_of_run marks
// the final beat of an operation.
// The queue is a row of slots that rotates by one slot per cycle, unless a
// stalled receiver pauses a drain, the oldest entry passing through the head,
// where it is either put back at the tail or dropped. Clear and a put into a
// full queue go straight to the result; a query surveys the row and then gives
// its result, and a plain append surveys, appends and then gives its result.
// Coalescing puts and drains that remove entries rotate the row twice, once to
// survey and once to remove; a put needs fewer than 16 queued entries.
// Input ready is high only while the sequencer is idle; an operation is taken
// even while the previous result beat still waits in the output register.
// When the receiver stalls, drain rotation pauses on each entry to be emitted.
// Reset empties the queue, sets the policy table to append for all types and
// the repeat window to 500 ms.
module coalescing_command_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TYPE_CODES  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [4:0]  cmd_type,
    input  logic [63:0] cmd_payload,
    input  logic [31:0] now_ms,
    input  logic [31:0] held_types,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  result_kind,
    output logic [4:0]  entry_type,
    output logic [63:0] entry_payload,
    output logic        type_found,
    output logic        dropped_full,
    output logic [4:0]  queue_level,
    output logic        last_of_run
);
    import ccq_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SURVEY,
        S_APPLY,
        S_APPEND,
        S_RESULT
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  op_reg, op_next;
    logic [4:0]  typ_reg, typ_next;
    logic [63:0] pay_reg, pay_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] held_reg, held_next;
    logic [1:0]  pol_reg, pol_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] remcnt_reg, remcnt_next;
    logic [CW-1:0] emitcnt_reg, emitcnt_next;
    logic [IW-1:0] step_reg, step_next;
    logic [IW-1:0] first_reg, first_next;
    logic [IW-1:0] last_reg, last_next;
    logic [31:0] ltime_reg, ltime_next;
    logic        found_reg, found_next;
    logic        multi_reg, multi_next;
    logic        dropped_reg, dropped_next;
    logic [2:0]  kind_reg, kind_next;
    logic [63:0] policy_reg, policy_next;
    logic [15:0] window_reg, window_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_kind_reg, out_kind_next;
    logic [4:0]  out_type_reg, out_type_next;
    logic [63:0] out_pay_reg, out_pay_next;
    logic        out_found_reg, out_found_next;
    logic        out_drop_reg, out_drop_next;
    logic [4:0]  out_level_reg, out_level_next;
    logic        out_last_reg, out_last_next;

    ccq_cell_ctrl_t ctrl;
    ccq_entry_t     cell_q [QUEUE_DEPTH];
    ccq_entry_t     nbr_ent [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] valid_vec, nbr_v, prev_v;
    ccq_entry_t     head, new_entry;

    logic step_last, head_match, head_held, win_hit, apply_rm, out_free, accept;
    logic [1:0] in_pol;
    logic [31:0] age;

    assign head      = cell_q[0];
    assign new_entry = '{typ: typ_reg, payload: pay_reg, stamp: now_reg};

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        if (i == QUEUE_DEPTH - 1)
        begin : g_end
            assign nbr_ent[i] = '0;
            assign nbr_v[i]   = 1'b0;
        end
        else
        begin : g_mid
            assign nbr_ent[i] = cell_q[i + 1];
            assign nbr_v[i]   = valid_vec[i + 1];
        end
        if (i == 0)
        begin : g_first
            assign prev_v[i] = 1'b1;
        end
        else
        begin : g_rest
            assign prev_v[i] = valid_vec[i - 1];
        end
        ccq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .head       (head),
            .nbr        (nbr_ent[i]),
            .new_entry  (new_entry),
            .nbr_valid  (nbr_v[i]),
            .prev_valid (prev_v[i]),
            .entry      (cell_q[i]),
            .valid      (valid_vec[i])
        );
    end

    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign step_last  = (CW'(step_reg) == (n_reg - CW'(1)));
    assign head_match = (head.typ == typ_reg);
    assign head_held  = held_reg[head.typ];
    assign age        = now_reg - ltime_reg;
    assign win_hit    = found_reg && (age < {16'd0, window_reg});

    always_comb
    begin
        if ({27'd0, cmd_type} < 32'(TYPE_CODES))
        begin
            in_pol = policy_reg[{cmd_type, 1'b0} +: 2];
        end
        else
        begin
            in_pol = POL_APPEND;
        end
    end

    // removal decision for the entry at the head during the second rotation
    always_comb
    begin
        apply_rm = 1'b0;
        if (op_reg == OP_DRAIN)
        begin
            apply_rm = !head_held;
        end
        else
        begin
            case (pol_reg)
                POL_REPLACE_ALL:  apply_rm = head_match;
                POL_REPLACE_LAST: apply_rm = step_last && head_match;
                POL_WINDOW:       apply_rm = ((step_reg == last_reg) && win_hit)
                                          || ((step_reg == first_reg) && multi_reg);
                default:          apply_rm = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        typ_next       = typ_reg;
        pay_next       = pay_reg;
        now_next       = now_reg;
        held_next      = held_reg;
        pol_next       = pol_reg;
        n_next         = n_reg;
        count_next     = count_reg;
        remcnt_next    = remcnt_reg;
        emitcnt_next   = emitcnt_reg;
        step_next      = step_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        ltime_next     = ltime_reg;
        found_next     = found_reg;
        multi_next     = multi_reg;
        dropped_next   = dropped_reg;
        kind_next      = kind_reg;
        policy_next    = policy_reg;
        window_next    = window_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_type_next  = out_type_reg;
        out_pay_next   = out_pay_reg;
        out_found_next = out_found_reg;
        out_drop_next  = out_drop_reg;
        out_level_next = out_level_reg;
        out_last_next  = out_last_reg;
        ctrl           = '0;

        if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_POLICY: policy_next = cfg_wdata;
                REG_WINDOW: window_next = cfg_wdata[15:0];
                default:    policy_next = policy_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = opcode;
                    typ_next     = cmd_type;
                    pay_next     = cmd_payload;
                    now_next     = now_ms;
                    held_next    = held_types;
                    pol_next     = in_pol;
                    n_next       = count_reg;
                    step_next    = '0;
                    remcnt_next  = '0;
                    emitcnt_next = '0;
                    found_next   = 1'b0;
                    multi_next   = 1'b0;
                    dropped_next = 1'b0;
                    if (opcode == OP_CLEAR)
                    begin
                        ctrl.clear = 1'b1;
                        count_next = '0;
                        kind_next  = KIND_CLEAR_ACK;
                        state_next = S_RESULT;
                    end
                    else if (opcode == OP_PUT && count_reg == CW'(QUEUE_DEPTH))
                    begin
                        dropped_next = 1'b1;
                        kind_next    = KIND_PUT_ACK;
                        state_next   = S_RESULT;
                    end
                    else if (count_reg == '0)
                    begin
                        if (opcode == OP_PUT)
                        begin
                            state_next = S_APPEND;
                        end
                        else
                        begin
                            kind_next  = (opcode == OP_QUERY) ? KIND_QUERY : KIND_NONE;
                            state_next = S_RESULT;
                        end
                    end
                    else
                    begin
                        state_next = S_SURVEY;
                    end
                end
            end

            S_SURVEY:
            begin
                // full rotation, everything kept, collecting match facts
                ctrl.shift_en  = 1'b1;
                ctrl.keep_head = 1'b1;
                step_next      = step_reg + IW'(1);
                if (head_match)
                begin
                    if (!found_reg)
                    begin
                        first_next = step_reg;
                    end
                    multi_next = found_reg;
                    found_next = 1'b1;
                    last_next  = step_reg;
                    ltime_next = head.stamp;
                end
                if (!head_held)
                begin
                    remcnt_next = remcnt_reg + CW'(1);
                end
                if (multi_reg)
                begin
                    multi_next = 1'b1;
                end
                if (step_last)
                begin
                    step_next = '0;
                    if (op_reg == OP_QUERY)
                    begin
                        kind_next  = KIND_QUERY;
                        state_next = S_RESULT;
                    end
                    else if (op_reg == OP_DRAIN)
                    begin
                        kind_next  = KIND_NONE;
                        state_next = (remcnt_next != '0) ? S_APPLY : S_RESULT;
                    end
                    else if (pol_reg == POL_REPLACE_ALL || pol_reg == POL_REPLACE_LAST
                             || (pol_reg == POL_WINDOW && window_reg != '0))
                    begin
                        state_next = S_APPLY;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end

            S_APPLY:
            begin
                if (!(op_reg == OP_DRAIN && apply_rm && !out_free))
                begin
                    ctrl.shift_en  = 1'b1;
                    ctrl.keep_head = !apply_rm;
                    step_next      = step_reg + IW'(1);
                    if (apply_rm)
                    begin
                        count_next = count_next - CW'(1);
                    end
                    if (op_reg == OP_DRAIN && apply_rm)
                    begin
                        emitcnt_next   = emitcnt_reg + CW'(1);
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_DRAINED;
                        out_type_next  = head.typ;
                        out_pay_next   = head.payload;
                        out_found_next = 1'b0;
                        out_drop_next  = 1'b0;
                        out_level_next = level5(32'(n_reg - remcnt_reg));
                        out_last_next  = (emitcnt_reg == (remcnt_reg - CW'(1)));
                    end
                    if (step_last)
                    begin
                        step_next  = '0;
                        state_next = (op_reg == OP_DRAIN) ? S_IDLE : S_APPEND;
                    end
                end
            end

            S_APPEND:
            begin
                ctrl.append_en = 1'b1;
                count_next     = count_reg + CW'(1);
                kind_next      = KIND_PUT_ACK;
                state_next     = S_RESULT;
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = kind_reg;
                    out_type_next  = '0;
                    out_pay_next   = '0;
                    out_found_next = found_reg && (kind_reg == KIND_QUERY);
                    out_drop_next  = dropped_reg;
                    out_level_next = level5(32'(count_reg));
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_PUT;
            typ_reg       <= '0;
            pay_reg       <= '0;
            now_reg       <= '0;
            held_reg      <= '0;
            pol_reg       <= POL_APPEND;
            n_reg         <= '0;
            count_reg     <= '0;
            remcnt_reg    <= '0;
            emitcnt_reg   <= '0;
            step_reg      <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            ltime_reg     <= '0;
            found_reg     <= 1'b0;
            multi_reg     <= 1'b0;
            dropped_reg   <= 1'b0;
            kind_reg      <= KIND_PUT_ACK;
            policy_reg    <= '0;
            window_reg    <= WINDOW_RESET;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_PUT_ACK;
            out_type_reg  <= '0;
            out_pay_reg   <= '0;
            out_found_reg <= 1'b0;
            out_drop_reg  <= 1'b0;
            out_level_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            typ_reg       <= typ_next;
            pay_reg       <= pay_next;
            now_reg       <= now_next;
            held_reg      <= held_next;
            pol_reg       <= pol_next;
            n_reg         <= n_next;
            count_reg     <= count_next;
            remcnt_reg    <= remcnt_next;
            emitcnt_reg   <= emitcnt_next;
            step_reg      <= step_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            ltime_reg     <= ltime_next;
            found_reg     <= found_next;
            multi_reg     <= multi_next;
            dropped_reg   <= dropped_next;
            kind_reg      <= kind_next;
            policy_reg    <= policy_next;
            window_reg    <= window_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_type_reg  <= out_type_next;
            out_pay_reg   <= out_pay_next;
            out_found_reg <= out_found_next;
            out_drop_reg  <= out_drop_next;
            out_level_reg <= out_level_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign result_kind   = out_kind_reg;
    assign entry_type    = out_type_reg;
    assign entry_payload = out_pay_reg;
    assign type_found    = out_found_reg;
    assign dropped_full  = out_drop_reg;
    assign queue_level   = out_level_reg;
    assign last_of_run   = out_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("fill count beyond queue depth");

    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("fill count disagrees with occupied slots");

    a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + QUEUE_DEPTH'(1)) & valid_vec) == '0)
        else $error("occupied slots not packed toward the head");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_pay_reg))
        else $error("pending result beat overwritten");
`endif

endmodule
